>>> src/phcc_pkg.sv
package phcc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IPV4  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IPV6H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IPV6L = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HTTP_THRESH = 3'd4;

    localparam logic [31:0] DEFAULT_THRESHOLD = 32'd1500;

    // event counters
    localparam int NUM_COUNTERS = 10;
    localparam int CNT_IDX_W    = 4;
    localparam int COUNT_OUT_W  = 32;

    typedef logic [CNT_IDX_W-1:0] cnt_idx_t;

    localparam cnt_idx_t CNT_ARP_REQ = 4'd0;
    localparam cnt_idx_t CNT_ARP_REP = 4'd1;
    localparam cnt_idx_t CNT_ICMP    = 4'd2;
    localparam cnt_idx_t CNT_ICMP6   = 4'd3;
    localparam cnt_idx_t CNT_IP      = 4'd4;
    localparam cnt_idx_t CNT_IP6     = 4'd5;
    localparam cnt_idx_t CNT_UDP     = 4'd6;
    localparam cnt_idx_t CNT_TCP     = 4'd7;
    localparam cnt_idx_t CNT_HTTP    = 4'd8;
    localparam cnt_idx_t CNT_SYN     = 4'd9;

    // result codes
    typedef logic [3:0] class_code_t;
    typedef logic [2:0] kind_code_t;

    localparam class_code_t CLS_OTHER      = 4'd0;
    localparam class_code_t CLS_ARP_REQ    = 4'd1;
    localparam class_code_t CLS_ARP_REP    = 4'd2;
    localparam class_code_t CLS_ARP_OTHER  = 4'd3;
    localparam class_code_t CLS_IP6_TCP    = 4'd4;
    localparam class_code_t CLS_IP6_UDP    = 4'd5;
    localparam class_code_t CLS_IP6_ICMP6  = 4'd6;
    localparam class_code_t CLS_IP6_OTHER  = 4'd7;
    localparam class_code_t CLS_IP4_TCP    = 4'd8;
    localparam class_code_t CLS_IP4_UDP    = 4'd9;
    localparam class_code_t CLS_IP4_ICMP   = 4'd10;
    localparam class_code_t CLS_IP4_OTHER  = 4'd11;
    localparam class_code_t CLS_NOT_LOCAL  = 4'd12;
    localparam class_code_t CLS_SHORT      = 4'd13;

    localparam kind_code_t KIND_NONE  = 3'd0;
    localparam kind_code_t KIND_RST   = 3'd1;
    localparam kind_code_t KIND_SYN   = 3'd2;
    localparam kind_code_t KIND_HTTP  = 3'd3;
    localparam kind_code_t KIND_PLAIN = 3'd4;

    // header fields
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;

    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [15:0] HTTP_PORT      = 16'd80;

    localparam int TCP_FLAG_RST = 2;
    localparam int TCP_FLAG_SYN = 1;

    // byte offsets in the frame
    localparam int POS_ETYPE_HI    = 12;
    localparam int POS_ETYPE_LO    = 13;
    localparam int POS_ARP_OP_HI   = 20;
    localparam int POS_ARP_OP_LO   = 21;
    localparam int POS_IP6_NEXT    = 20;
    localparam int POS_IP6_DST     = 38;
    localparam int POS_IP6_DST_END = 54;
    localparam int POS_IP4_IHL     = 14;
    localparam int POS_IP4_PROTO   = 23;
    localparam int POS_IP4_DST     = 30;
    localparam int POS_IP4_DST_END = 34;

    localparam int TCP_OFF_SRC_HI = 0;
    localparam int TCP_OFF_SRC_LO = 1;
    localparam int TCP_OFF_DST_HI = 2;
    localparam int TCP_OFF_DST_LO = 3;
    localparam int TCP_OFF_FLAGS  = 13;

    // minimum lengths
    localparam int LEN_ETH  = 14;
    localparam int LEN_ARP  = 22;
    localparam int LEN_IP6  = 54;
    localparam int LEN_IP4  = 34;
    localparam int TCP_SPAN = 14;

    // counter slots of one frame: protocol, ip, flag
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_PROTO = 0;
    localparam int SLOT_IP    = 1;
    localparam int SLOT_FLAG  = 2;

    typedef logic [1:0] step_t;
    localparam step_t STEP_DONE = 2'd3;

    typedef struct packed {
        class_code_t                   cls;
        kind_code_t                    kind;
        logic [NUM_SLOTS-1:0]          bump;
        cnt_idx_t [NUM_SLOTS-1:0]      idx;
        logic                          syn_check;
        logic                          http_check;
    } job_t;

endpackage

>>> src/packet_header_classifier_counters.sv
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// frame    | frame_valid / frame_ready  | frame_byte, frame_end
// result   | result_valid / result_ready| frame_class, tcp_kind, protocol_count,
//          |                            | ip_count, flag_count, syn_flood_alarm,
//          |                            | slowloris_alarm
// config   | cfg_write                  | cfg_index, cfg_data
//
// One byte is taken every cycle. A frame's result goes from the job register to the result
// register directly when no counter changes; when counters are bumped, up to three counters
// first go through the read and write ports of the counter RAM one after another.
// A last byte waits (frame_ready low) only while the previous frame's result is still
// in the counter update or held by a stalled result register; other bytes never wait.
// Reset clears the counters at once through per-entry valid bits; no clearing pass.
module packet_header_classifier_counters #(
    parameter int MAX_FRAME_BYTES = 65536,
    parameter int COUNTER_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               frame_valid,
    output logic                               frame_ready,
    input  logic [7:0]                         frame_byte,
    input  logic                               frame_end,

    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [3:0]                         frame_class,
    output logic [2:0]                         tcp_kind,
    output logic [phcc_pkg::COUNT_OUT_W-1:0]   protocol_count,
    output logic [phcc_pkg::COUNT_OUT_W-1:0]   ip_count,
    output logic [phcc_pkg::COUNT_OUT_W-1:0]   flag_count,
    output logic                               syn_flood_alarm,
    output logic                               slowloris_alarm,

    input  logic                               cfg_write,
    input  logic [phcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [phcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import phcc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;

    // configuration
    logic [31:0]           local_ipv4_reg;
    logic [63:0]           local_ipv6h_reg;
    logic [63:0]           local_ipv6l_reg;
    logic [31:0]           syn_thresh_reg;
    logic [31:0]           http_thresh_reg;

    // per-frame parse state
    logic [POS_W-1:0]      pos_reg;
    logic [15:0]           etype_reg;
    logic [15:0]           arp_op_reg;
    logic [7:0]            proto_reg;
    logic [3:0]            ihl_reg;
    logic                  addr_match_reg;
    logic [15:0]           src_port_reg;
    logic [15:0]           dst_port_reg;
    logic [7:0]            tcp_flags_reg;

    logic [POS_W-1:0]      pos_next;
    logic [15:0]           etype_next;
    logic [15:0]           arp_op_next;
    logic [7:0]            proto_next;
    logic [3:0]            ihl_next;
    logic                  addr_match_next;
    logic [15:0]           src_port_next;
    logic [15:0]           dst_port_next;
    logic [7:0]            tcp_flags_next;

    logic                  take;
    logic [3:0]            ip6_k;
    logic [1:0]            ip4_j;
    logic [15:0][7:0]      ip6_bytes;
    logic [3:0][7:0]       ip4_bytes;
    logic [POS_W-1:0]      tcp_base;
    logic [POS_W-1:0]      tcp_rel;
    logic                  in_tcp;

    // frame job and counter update
    job_t                  new_job;
    job_t                  job_reg;
    logic                  job_valid_reg;
    step_t                 step_reg;
    logic                  rd_pend_reg;
    logic [1:0]            rd_slot_reg;
    logic [NUM_SLOTS-1:0][COUNT_OUT_W-1:0] cnt_val_reg;
    logic                  syn_alarm_reg;
    logic                  http_alarm_reg;

    logic [COUNTER_BITS-1:0] cnt_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] cnt_valid_reg;
    logic [COUNTER_BITS-1:0] rd_data_reg;
    logic                    rd_zero_reg;

    logic                  slot_en;
    cnt_idx_t              rd_addr;
    cnt_idx_t              wr_addr;
    logic                  rd_issue;
    logic                  wr_en;
    logic [COUNTER_BITS-1:0] cnt_old;
    logic [COUNTER_BITS-1:0] cnt_inc;

    logic                  job_done;
    logic                  out_free;
    logic                  job_leave;
    logic                  job_free;
    logic                  accept;
    logic                  end_accept;

    // result register
    logic                  result_valid_reg;
    class_code_t           class_reg;
    kind_code_t            kind_reg;
    logic [COUNT_OUT_W-1:0] proto_cnt_reg;
    logic [COUNT_OUT_W-1:0] ip_cnt_reg;
    logic [COUNT_OUT_W-1:0] flag_cnt_reg;
    logic                  syn_out_reg;
    logic                  http_out_reg;

    // ------------------------------------------------------------------ handshake
    assign job_done   = job_valid_reg && (step_reg == STEP_DONE) && !rd_pend_reg;
    assign out_free   = !result_valid_reg || result_ready;
    assign job_leave  = job_done && out_free;
    assign job_free   = !job_valid_reg || job_leave;
    assign frame_ready = !frame_end || job_free;
    assign accept     = frame_valid && frame_ready;
    assign end_accept = accept && frame_end;

    // ------------------------------------------------------------------ configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ipv4_reg  <= '0;
            local_ipv6h_reg <= '0;
            local_ipv6l_reg <= '0;
            syn_thresh_reg  <= DEFAULT_THRESHOLD;
            http_thresh_reg <= DEFAULT_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOCAL_IPV4:  local_ipv4_reg  <= cfg_data[31:0];
                REG_LOCAL_IPV6H: local_ipv6h_reg <= cfg_data;
                REG_LOCAL_IPV6L: local_ipv6l_reg <= cfg_data;
                REG_SYN_THRESH:  syn_thresh_reg  <= cfg_data[31:0];
                REG_HTTP_THRESH: http_thresh_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ byte parser
    assign ip6_bytes = {local_ipv6h_reg, local_ipv6l_reg};
    assign ip4_bytes = local_ipv4_reg;

    always_comb
    begin
        take            = pos_reg < POS_W'(MAX_FRAME_BYTES);
        etype_next      = etype_reg;
        arp_op_next     = arp_op_reg;
        proto_next      = proto_reg;
        ihl_next        = ihl_reg;
        addr_match_next = addr_match_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;
        tcp_flags_next  = tcp_flags_reg;
        ip6_k           = 4'(pos_reg - POS_W'(POS_IP6_DST));
        ip4_j           = 2'(pos_reg - POS_W'(POS_IP4_DST));

        if (take)
        begin
            if (pos_reg == POS_W'(POS_ETYPE_HI))
                etype_next = {frame_byte, 8'h00};
            if (pos_reg == POS_W'(POS_ETYPE_LO))
                etype_next = {etype_reg[15:8], frame_byte};
            if (etype_next == ETH_IPV4 && pos_reg == POS_W'(POS_IP4_IHL))
                ihl_next = frame_byte[3:0];
        end

        // TCP header starts at 14 + 4*IHL, with the IHL as of this byte
        tcp_base = POS_W'(LEN_ETH) + POS_W'({ihl_next, 2'b00});
        tcp_rel  = pos_reg - tcp_base;
        in_tcp   = (pos_reg >= tcp_base) && (tcp_rel < POS_W'(TCP_SPAN));

        if (take)
        begin
            case (etype_next)
                ETH_ARP:
                begin
                    if (pos_reg == POS_W'(POS_ARP_OP_HI))
                        arp_op_next = {frame_byte, 8'h00};
                    if (pos_reg == POS_W'(POS_ARP_OP_LO))
                        arp_op_next = {arp_op_reg[15:8], frame_byte};
                end
                ETH_IPV6:
                begin
                    if (pos_reg == POS_W'(POS_IP6_NEXT))
                        proto_next = frame_byte;
                    if (pos_reg >= POS_W'(POS_IP6_DST) && pos_reg < POS_W'(POS_IP6_DST_END)
                        && ip6_bytes[~ip6_k] != frame_byte)
                        addr_match_next = 1'b0;
                end
                ETH_IPV4:
                begin
                    if (pos_reg == POS_W'(POS_IP4_PROTO))
                        proto_next = frame_byte;
                    if (pos_reg >= POS_W'(POS_IP4_DST) && pos_reg < POS_W'(POS_IP4_DST_END)
                        && ip4_bytes[~ip4_j] != frame_byte)
                        addr_match_next = 1'b0;
                    if (in_tcp)
                    begin
                        case (4'(tcp_rel))
                            4'(TCP_OFF_SRC_HI): src_port_next  = {frame_byte, 8'h00};
                            4'(TCP_OFF_SRC_LO): src_port_next  = {src_port_reg[15:8], frame_byte};
                            4'(TCP_OFF_DST_HI): dst_port_next  = {frame_byte, 8'h00};
                            4'(TCP_OFF_DST_LO): dst_port_next  = {dst_port_reg[15:8], frame_byte};
                            4'(TCP_OFF_FLAGS):  tcp_flags_next = frame_byte;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        // bytes past the limit are dropped, the length stops there
        pos_next = take ? pos_reg + 1'b1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            etype_reg      <= '0;
            arp_op_reg     <= '0;
            proto_reg      <= '0;
            ihl_reg        <= '0;
            addr_match_reg <= 1'b1;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
            tcp_flags_reg  <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                pos_reg        <= '0;
                etype_reg      <= '0;
                arp_op_reg     <= '0;
                proto_reg      <= '0;
                ihl_reg        <= '0;
                addr_match_reg <= 1'b1;
                src_port_reg   <= '0;
                dst_port_reg   <= '0;
                tcp_flags_reg  <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                etype_reg      <= etype_next;
                arp_op_reg     <= arp_op_next;
                proto_reg      <= proto_next;
                ihl_reg        <= ihl_next;
                addr_match_reg <= addr_match_next;
                src_port_reg   <= src_port_next;
                dst_port_reg   <= dst_port_next;
                tcp_flags_reg  <= tcp_flags_next;
            end
        end
    end

    // ------------------------------------------------------------------ frame decision
    always_comb
    begin
        new_job            = '0;
        new_job.cls        = CLS_OTHER;
        new_job.kind       = KIND_NONE;

        if (pos_next < POS_W'(LEN_ETH))
            new_job.cls = CLS_SHORT;
        else
        begin
            case (etype_next)
                ETH_ARP:
                begin
                    if (pos_next < POS_W'(LEN_ARP))
                        new_job.cls = CLS_SHORT;
                    else if (arp_op_next == ARP_OP_REQUEST)
                    begin
                        new_job.cls              = CLS_ARP_REQ;
                        new_job.bump[SLOT_PROTO] = 1'b1;
                        new_job.idx[SLOT_PROTO]  = CNT_ARP_REQ;
                    end
                    else if (arp_op_next == ARP_OP_REPLY)
                    begin
                        new_job.cls              = CLS_ARP_REP;
                        new_job.bump[SLOT_PROTO] = 1'b1;
                        new_job.idx[SLOT_PROTO]  = CNT_ARP_REP;
                    end
                    else
                        new_job.cls = CLS_ARP_OTHER;
                end
                ETH_IPV6:
                begin
                    if (pos_next < POS_W'(LEN_IP6))
                        new_job.cls = CLS_SHORT;
                    else if (!addr_match_next)
                        new_job.cls = CLS_NOT_LOCAL;
                    else
                    begin
                        new_job.bump[SLOT_IP] = 1'b1;
                        new_job.idx[SLOT_IP]  = CNT_IP6;
                        new_job.bump[SLOT_PROTO] = 1'b1;
                        case (proto_next)
                            PROTO_TCP:
                            begin
                                new_job.cls             = CLS_IP6_TCP;
                                new_job.idx[SLOT_PROTO] = CNT_TCP;
                            end
                            PROTO_UDP:
                            begin
                                new_job.cls             = CLS_IP6_UDP;
                                new_job.idx[SLOT_PROTO] = CNT_UDP;
                            end
                            PROTO_ICMP6:
                            begin
                                new_job.cls             = CLS_IP6_ICMP6;
                                new_job.idx[SLOT_PROTO] = CNT_ICMP6;
                            end
                            default:
                            begin
                                new_job.cls              = CLS_IP6_OTHER;
                                new_job.bump[SLOT_PROTO] = 1'b0;
                            end
                        endcase
                    end
                end
                ETH_IPV4:
                begin
                    if (pos_next < POS_W'(LEN_IP4))
                        new_job.cls = CLS_SHORT;
                    else if (!addr_match_next)
                        new_job.cls = CLS_NOT_LOCAL;
                    else if (proto_next == PROTO_TCP
                             && pos_next < tcp_base + POS_W'(TCP_SPAN))
                        new_job.cls = CLS_SHORT;
                    else
                    begin
                        new_job.bump[SLOT_IP]    = 1'b1;
                        new_job.idx[SLOT_IP]     = CNT_IP;
                        new_job.bump[SLOT_PROTO] = 1'b1;
                        case (proto_next)
                            PROTO_TCP:
                            begin
                                new_job.cls             = CLS_IP4_TCP;
                                new_job.idx[SLOT_PROTO] = CNT_TCP;
                                if (tcp_flags_next[TCP_FLAG_RST])
                                    new_job.kind = KIND_RST;
                                else if (tcp_flags_next[TCP_FLAG_SYN])
                                begin
                                    new_job.kind            = KIND_SYN;
                                    new_job.bump[SLOT_FLAG] = 1'b1;
                                    new_job.idx[SLOT_FLAG]  = CNT_SYN;
                                    new_job.syn_check       = 1'b1;
                                end
                                else if (dst_port_next == HTTP_PORT
                                         || src_port_next == HTTP_PORT)
                                begin
                                    new_job.kind            = KIND_HTTP;
                                    new_job.bump[SLOT_FLAG] = 1'b1;
                                    new_job.idx[SLOT_FLAG]  = CNT_HTTP;
                                    new_job.http_check      = 1'b1;
                                end
                                else
                                    new_job.kind = KIND_PLAIN;
                            end
                            PROTO_UDP:
                            begin
                                new_job.cls             = CLS_IP4_UDP;
                                new_job.idx[SLOT_PROTO] = CNT_UDP;
                            end
                            PROTO_ICMP:
                            begin
                                new_job.cls             = CLS_IP4_ICMP;
                                new_job.idx[SLOT_PROTO] = CNT_ICMP;
                            end
                            default:
                            begin
                                new_job.cls              = CLS_IP4_OTHER;
                                new_job.bump[SLOT_PROTO] = 1'b0;
                            end
                        endcase
                    end
                end
                default: new_job.cls = CLS_OTHER;
            endcase
        end
    end

    // ------------------------------------------------------------------ counter update
    // Slots are walked in order: read in one cycle, increment and write back in the next.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                slot_en = job_reg.bump[0];
                rd_addr = job_reg.idx[0];
            end
            2'd1:
            begin
                slot_en = job_reg.bump[1];
                rd_addr = job_reg.idx[1];
            end
            2'd2:
            begin
                slot_en = job_reg.bump[2];
                rd_addr = job_reg.idx[2];
            end
            default:
            begin
                slot_en = 1'b0;
                rd_addr = job_reg.idx[2];
            end
        endcase
    end

    assign rd_issue = job_valid_reg && (step_reg != STEP_DONE) && slot_en;
    assign wr_en    = job_valid_reg && rd_pend_reg;
    assign wr_addr  = job_reg.idx[rd_slot_reg];
    assign cnt_old  = rd_zero_reg ? '0 : rd_data_reg;
    assign cnt_inc  = (cnt_old == {COUNTER_BITS{1'b1}}) ? cnt_old : cnt_old + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cnt_mem[wr_addr] <= cnt_inc;
        rd_data_reg <= cnt_mem[rd_addr];
        rd_zero_reg <= !cnt_valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_valid_reg <= '0;
        else if (wr_en)
            cnt_valid_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_DONE;
            rd_pend_reg   <= 1'b0;
            rd_slot_reg   <= '0;
        end
        else if (end_accept)
        begin
            job_valid_reg <= 1'b1;
            step_reg      <= (|new_job.bump) ? 2'd0 : STEP_DONE;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            if (job_leave)
                job_valid_reg <= 1'b0;
            if (job_valid_reg && step_reg != STEP_DONE)
            begin
                step_reg    <= step_reg + 1'b1;
                rd_pend_reg <= slot_en;
                rd_slot_reg <= step_reg;
            end
            else
                rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_accept)
        begin
            job_reg        <= new_job;
            cnt_val_reg    <= '0;
            syn_alarm_reg  <= 1'b0;
            http_alarm_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            cnt_val_reg[rd_slot_reg] <= COUNT_OUT_W'(cnt_inc);
            if (rd_slot_reg == 2'(SLOT_FLAG))
            begin
                syn_alarm_reg  <= job_reg.syn_check
                                  && (CMP_W'(cnt_inc) > CMP_W'(syn_thresh_reg));
                http_alarm_reg <= job_reg.http_check
                                  && (CMP_W'(cnt_inc) > CMP_W'(http_thresh_reg));
            end
        end
    end

    // ------------------------------------------------------------------ result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (job_leave)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (job_leave)
        begin
            class_reg     <= job_reg.cls;
            kind_reg      <= job_reg.kind;
            proto_cnt_reg <= cnt_val_reg[SLOT_PROTO];
            ip_cnt_reg    <= cnt_val_reg[SLOT_IP];
            flag_cnt_reg  <= cnt_val_reg[SLOT_FLAG];
            syn_out_reg   <= syn_alarm_reg;
            http_out_reg  <= http_alarm_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign frame_class     = class_reg;
    assign tcp_kind        = kind_reg;
    assign protocol_count  = proto_cnt_reg;
    assign ip_count        = ip_cnt_reg;
    assign flag_count      = flag_cnt_reg;
    assign syn_flood_alarm = syn_out_reg;
    assign slowloris_alarm = http_out_reg;

`ifndef SYNTHESIS
    // slots of one job hold distinct counters, so a read never meets the pending write
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_issue) |-> (rd_addr != wr_addr))
        else $error("counter read and write hit the same entry");

    a_write_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> job_valid_reg)
        else $error("counter write without a frame job");

    a_kind_only_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && tcp_kind != KIND_NONE) |-> (frame_class == CLS_IP4_TCP))
        else $error("tcp kind on a frame that is not local IPv4 TCP");

    a_alarm_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (syn_flood_alarm || slowloris_alarm))
            |-> (tcp_kind == KIND_SYN || tcp_kind == KIND_HTTP))
        else $error("alarm raised without a SYN or port 80 segment");

    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        end_accept |=> (pos_reg == '0 && addr_match_reg))
        else $error("frame state not cleared after last byte");
`endif

endmodule

>>> tb/tb_packet_header_classifier_counters.sv
module tb_packet_header_classifier_counters;
    import phcc_pkg::*;

    localparam int FRAME_LIMIT   = 65536;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    localparam logic [15:0] ETH_LLDP = 16'h88CC;
    localparam logic [7:0]  RST_BIT  = 8'(1 << TCP_FLAG_RST);
    localparam logic [7:0]  SYN_BIT  = 8'(1 << TCP_FLAG_SYN);
    localparam logic [7:0]  ACK_BIT  = 8'h10;

    typedef struct packed {
        class_code_t cls;
        kind_code_t  kind;
        logic [31:0] proto_cnt;
        logic [31:0] ip_cnt;
        logic [31:0] flag_cnt;
        logic        syn_alarm;
        logic        http_alarm;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  frame_valid;
    logic                  frame_ready;
    logic [7:0]            frame_byte;
    logic                  frame_end;
    logic                  result_valid;
    logic                  result_ready;
    logic [3:0]            frame_class;
    logic [2:0]            tcp_kind;
    logic [31:0]           protocol_count;
    logic [31:0]           ip_count;
    logic [31:0]           flag_count;
    logic                  syn_flood_alarm;
    logic                  slowloris_alarm;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    packet_header_classifier_counters DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .frame_byte      (frame_byte),
        .frame_end       (frame_end),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .frame_class     (frame_class),
        .tcp_kind        (tcp_kind),
        .protocol_count  (protocol_count),
        .ip_count        (ip_count),
        .flag_count      (flag_count),
        .syn_flood_alarm (syn_flood_alarm),
        .slowloris_alarm (slowloris_alarm),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // register mirror
    logic [31:0] cfg_v4       = '0;
    logic [63:0] cfg_v6_hi    = '0;
    logic [63:0] cfg_v6_lo    = '0;
    logic [31:0] cfg_syn_thr  = DEFAULT_THRESHOLD;
    logic [31:0] cfg_http_thr = DEFAULT_THRESHOLD;

    // per-frame parse state and event counters
    int unsigned fpos      = 0;
    logic [15:0] etype     = '0;
    logic [15:0] arp_op    = '0;
    logic [7:0]  l3_proto  = '0;
    logic [3:0]  ihl_words = '0;
    logic        dst_hit   = 1'b1;
    logic [15:0] sport     = '0;
    logic [15:0] dport     = '0;
    logic [7:0]  tflags    = '0;
    logic [31:0] counts [NUM_COUNTERS];

    verdict_t    verdicts_due[$];
    logic [7:0]  pkt[$];
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    int          hold_len    = 0;
    bit          calm        = 1'b0;

    initial begin
        for (int i = 0; i < NUM_COUNTERS; i++)
            counts[i] = '0;
    end

    function automatic logic [31:0] bump_count(cnt_idx_t i);
        if (counts[i] != 32'hFFFF_FFFF)
            counts[i] = counts[i] + 32'd1;
        return counts[i];
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        int unsigned p;
        int unsigned t;
        int unsigned k;
        logic [63:0] word;
        p = fpos;
        if (p == POS_ETYPE_HI) etype = {b, 8'h00};
        if (p == POS_ETYPE_LO) etype = etype | {8'h00, b};
        if (etype == ETH_ARP) begin
            if (p == POS_ARP_OP_HI) arp_op = {b, 8'h00};
            if (p == POS_ARP_OP_LO) arp_op = arp_op | {8'h00, b};
        end else if (etype == ETH_IPV6) begin
            if (p == POS_IP6_NEXT) l3_proto = b;
            if (p >= POS_IP6_DST && p < POS_IP6_DST_END) begin
                k = p - POS_IP6_DST;
                word = (k < 8) ? cfg_v6_hi : cfg_v6_lo;
                if (8'(word >> (56 - 8 * (k % 8))) != b) dst_hit = 1'b0;
            end
        end else if (etype == ETH_IPV4) begin
            if (p == POS_IP4_IHL) ihl_words = b[3:0];
            if (p == POS_IP4_PROTO) l3_proto = b;
            if (p >= POS_IP4_DST && p < POS_IP4_DST_END) begin
                if (8'(cfg_v4 >> (24 - 8 * (p - POS_IP4_DST))) != b) dst_hit = 1'b0;
            end
            // TCP header position moves with IHL, even when IHL is below 5
            t = LEN_ETH + 4 * ihl_words;
            if (p >= t && p < t + TCP_SPAN) begin
                case (p - t)
                    TCP_OFF_SRC_HI: sport = {b, 8'h00};
                    TCP_OFF_SRC_LO: sport = sport | {8'h00, b};
                    TCP_OFF_DST_HI: dport = {b, 8'h00};
                    TCP_OFF_DST_LO: dport = dport | {8'h00, b};
                    TCP_OFF_FLAGS:  tflags = b;
                    default: ;
                endcase
            end
        end
    endfunction

    function automatic verdict_t classify_frame();
        verdict_t v;
        int unsigned need;
        v = '0;
        need = LEN_ETH + 4 * ihl_words + TCP_SPAN;
        if (fpos < LEN_ETH) begin
            v.cls = CLS_SHORT;
        end else if (etype == ETH_ARP) begin
            if (fpos < LEN_ARP) v.cls = CLS_SHORT;
            else if (arp_op == ARP_OP_REQUEST) begin
                v.cls = CLS_ARP_REQ;
                v.proto_cnt = bump_count(CNT_ARP_REQ);
            end else if (arp_op == ARP_OP_REPLY) begin
                v.cls = CLS_ARP_REP;
                v.proto_cnt = bump_count(CNT_ARP_REP);
            end else v.cls = CLS_ARP_OTHER;
        end else if (etype == ETH_IPV6) begin
            if (fpos < LEN_IP6) v.cls = CLS_SHORT;
            else if (!dst_hit) v.cls = CLS_NOT_LOCAL;
            else begin
                case (l3_proto)
                    PROTO_TCP:
                    begin
                        v.cls = CLS_IP6_TCP;
                        v.proto_cnt = bump_count(CNT_TCP);
                    end
                    PROTO_UDP:
                    begin
                        v.cls = CLS_IP6_UDP;
                        v.proto_cnt = bump_count(CNT_UDP);
                    end
                    PROTO_ICMP6:
                    begin
                        v.cls = CLS_IP6_ICMP6;
                        v.proto_cnt = bump_count(CNT_ICMP6);
                    end
                    default: v.cls = CLS_IP6_OTHER;
                endcase
                v.ip_cnt = bump_count(CNT_IP6);
            end
        end else if (etype == ETH_IPV4) begin
            if (fpos < LEN_IP4) v.cls = CLS_SHORT;
            else if (!dst_hit) v.cls = CLS_NOT_LOCAL;
            else if (l3_proto == PROTO_TCP && fpos < need) v.cls = CLS_SHORT;
            else begin
                case (l3_proto)
                    PROTO_TCP:
                    begin
                        v.cls = CLS_IP4_TCP;
                        v.proto_cnt = bump_count(CNT_TCP);
                        // RST beats SYN, SYN beats port 80
                        if (tflags[TCP_FLAG_RST]) v.kind = KIND_RST;
                        else if (tflags[TCP_FLAG_SYN]) begin
                            v.kind = KIND_SYN;
                            v.flag_cnt = bump_count(CNT_SYN);
                            v.syn_alarm = v.flag_cnt > cfg_syn_thr;
                        end else if (dport == HTTP_PORT || sport == HTTP_PORT) begin
                            v.kind = KIND_HTTP;
                            v.flag_cnt = bump_count(CNT_HTTP);
                            v.http_alarm = v.flag_cnt > cfg_http_thr;
                        end else v.kind = KIND_PLAIN;
                    end
                    PROTO_UDP:
                    begin
                        v.cls = CLS_IP4_UDP;
                        v.proto_cnt = bump_count(CNT_UDP);
                    end
                    PROTO_ICMP:
                    begin
                        v.cls = CLS_IP4_ICMP;
                        v.proto_cnt = bump_count(CNT_ICMP);
                    end
                    default: v.cls = CLS_IP4_OTHER;
                endcase
                v.ip_cnt = bump_count(CNT_IP);
            end
        end else begin
            v.cls = CLS_OTHER;
        end
        fpos = 0;
        etype = '0;
        arp_op = '0;
        l3_proto = '0;
        ihl_words = '0;
        dst_hit = 1'b1;
        sport = '0;
        dport = '0;
        tflags = '0;
        return v;
    endfunction

    function automatic void take_item(logic [7:0] b, logic last);
        // bytes past the size limit are dropped
        if (fpos < FRAME_LIMIT) begin
            absorb_byte(b);
            fpos++;
        end
        if (last)
            verdicts_due.push_back(classify_frame());
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        verdict_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected, class expected none actual %0d",
                         $time, frame_class);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("frame_class", want.cls, frame_class);
                check_field("tcp_kind", want.kind, tcp_kind);
                check_field("protocol_count", want.proto_cnt, protocol_count);
                check_field("ip_count", want.ip_cnt, ip_count);
                check_field("flag_count", want.flag_cnt, flag_count);
                check_field("syn_flood_alarm", want.syn_alarm, syn_flood_alarm);
                check_field("slowloris_alarm", want.http_alarm, slowloris_alarm);
            end
        end
    end

    initial begin : result_sink
        int n;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
                result_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_ready <= 1'b1;
            end else if ($urandom_range(0, 39) == 0) begin
                // stretch with no stall
                result_ready <= 1'b1;
                repeat (40) @(posedge clk);
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last, bit no_gap);
        frame_valid <= 1'b1;
        frame_byte  <= b;
        frame_end   <= last;
        do @(posedge clk); while (frame_ready !== 1'b1);
        take_item(b, last);
        if (!no_gap && !calm && $urandom_range(0, 9) == 0) begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_frame(bit smooth);
        int n;
        n = pkt.size();
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], i == n - 1, smooth);
        bytes_sent += n;
        frames_sent++;
    endtask

    task automatic wait_idle();
        frame_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LOCAL_IPV4:  cfg_v4 = val[31:0];
            REG_LOCAL_IPV6H: cfg_v6_hi = val;
            REG_LOCAL_IPV6L: cfg_v6_lo = val;
            REG_SYN_THRESH:  cfg_syn_thr = val[31:0];
            REG_HTTP_THRESH: cfg_http_thr = val[31:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void fill_random(int len);
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put(int pos, logic [7:0] v);
        if (pos >= 0 && pos < pkt.size())
            pkt[pos] = v;
    endfunction

    function automatic void put16(int pos, logic [15:0] v);
        put(pos, v[15:8]);
        put(pos + 1, v[7:0]);
    endfunction

    function automatic void make_arp(int len, logic [15:0] op);
        fill_random(len);
        put16(POS_ETYPE_HI, ETH_ARP);
        put16(POS_ARP_OP_HI, op);
    endfunction

    // miss < 0: exact local address, else that address byte is corrupted
    function automatic void make_ip6(int len, logic [7:0] nxt, int miss);
        logic [7:0] a;
        fill_random(len);
        put16(POS_ETYPE_HI, ETH_IPV6);
        put(POS_IP6_NEXT, nxt);
        for (int k = 0; k < 16; k++) begin
            a = (k < 8) ? cfg_v6_hi[63 - 8 * k -: 8] : cfg_v6_lo[127 - 8 * k -: 8];
            if (k == miss) a = a ^ 8'($urandom_range(1, 255));
            put(POS_IP6_DST + k, a);
        end
    endfunction

    function automatic void make_ip4(int len, logic [3:0] ihl, logic [7:0] proto, int miss,
                                     logic [15:0] sp, logic [15:0] dp, logic [7:0] flags);
        int t;
        logic [7:0] a;
        fill_random(len);
        put16(POS_ETYPE_HI, ETH_IPV4);
        t = LEN_ETH + 4 * ihl;
        put16(t + TCP_OFF_SRC_HI, sp);
        put16(t + TCP_OFF_DST_HI, dp);
        put(t + TCP_OFF_FLAGS, flags);
        put(POS_IP4_PROTO, proto);
        put(POS_IP4_IHL, {4'($urandom), ihl});
        for (int k = 0; k < 4; k++) begin
            a = cfg_v4[31 - 8 * k -: 8];
            if (k == miss) a = a ^ 8'($urandom_range(1, 255));
            put(POS_IP4_DST + k, a);
        end
    endfunction

    function automatic void make_tcp4(logic [7:0] flags, logic [15:0] sp, logic [15:0] dp);
        make_ip4(LEN_ETH + 20 + TCP_SPAN + 6, 4'd5, PROTO_TCP, -1, sp, dp, flags);
    endfunction

    task automatic random_frame();
        int pick;
        int len;
        int need;
        int miss;
        logic [15:0] op;
        logic [7:0]  nxt;
        logic [3:0]  ihl;
        logic [7:0]  flags;
        logic [15:0] sp;
        logic [15:0] dp;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 6) != 0) miss = -1;
        else miss = $urandom_range(0, 15);
        if (pick < 8) begin
            fill_random($urandom_range(1, LEN_ETH - 1));
        end else if (pick < 13) begin
            fill_random($urandom_range(LEN_ETH, 80));
        end else if (pick < 25) begin
            case ($urandom_range(0, 2))
                0: op = ARP_OP_REQUEST;
                1: op = ARP_OP_REPLY;
                default: op = 16'($urandom);
            endcase
            if ($urandom_range(0, 9) != 0) len = $urandom_range(LEN_ARP, 64);
            else len = $urandom_range(LEN_ETH, LEN_ARP - 1);
            make_arp(len, op);
        end else if (pick < 45) begin
            case ($urandom_range(0, 3))
                0: nxt = PROTO_TCP;
                1: nxt = PROTO_UDP;
                2: nxt = PROTO_ICMP6;
                default: nxt = 8'($urandom);
            endcase
            if ($urandom_range(0, 9) != 0) len = $urandom_range(LEN_IP6, 90);
            else len = $urandom_range(LEN_ETH, LEN_IP6 - 1);
            make_ip6(len, nxt, miss);
        end else begin
            if ($urandom_range(0, 9) < 7) ihl = 4'd5;
            else ihl = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0, 1, 2: nxt = PROTO_TCP;
                3: nxt = PROTO_UDP;
                4: nxt = PROTO_ICMP;
                default: nxt = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: flags = 8'($urandom) | RST_BIT;
                1: flags = (8'($urandom) & ~RST_BIT) | SYN_BIT;
                2: flags = 8'($urandom) & ~(RST_BIT | SYN_BIT);
                default: flags = 8'($urandom);
            endcase
            sp = ($urandom_range(0, 3) == 0) ? HTTP_PORT : 16'($urandom);
            dp = ($urandom_range(0, 3) == 0) ? HTTP_PORT : 16'($urandom);
            need = LEN_ETH + 4 * ihl + TCP_SPAN;
            if (need < LEN_IP4) need = LEN_IP4;
            if ($urandom_range(0, 9) != 0) len = $urandom_range(need, need + 24);
            else len = $urandom_range(LEN_ETH, need - 1);
            make_ip4(len, ihl, nxt, (miss < 0) ? -1 : miss % 4, sp, dp, flags);
        end
    endtask

    task automatic run_traffic(int byte_budget, int min_frames);
        int b0;
        int f0;
        b0 = bytes_sent;
        f0 = frames_sent;
        while (bytes_sent - b0 < byte_budget || frames_sent - f0 < min_frames) begin
            random_frame();
            send_frame($urandom_range(0, 3) == 0);
        end
    endtask

    // addresses still zero, thresholds at their defaults
    task automatic test_reset_config();
        make_tcp4(SYN_BIT, 16'd1234, 16'd22);
        send_frame(0);
        make_ip6(60, PROTO_UDP, -1);
        send_frame(0);
    endtask

    task automatic test_register_writes();
        wait_idle();
        set_reg(REG_LOCAL_IPV4, rand64());
        set_reg(REG_LOCAL_IPV6H, rand64());
        set_reg(REG_LOCAL_IPV6L, rand64());
        set_reg(REG_SYN_THRESH, rand64());
        set_reg(REG_HTTP_THRESH, rand64());
        // indexes past the last register are ignored
        set_reg(REG_SPARE, rand64());
        set_reg(REG_SPARE + 3'd1, '1);
        set_reg(REG_SPARE + 3'd2, rand64());
    endtask

    task automatic test_frame_classes();
        fill_random(60);
        put16(POS_ETYPE_HI, ETH_LLDP);
        send_frame(0);
        pkt.delete();
        repeat (20) pkt.push_back(8'hFF);
        send_frame(0);
        pkt.delete();
        repeat (LEN_ETH) pkt.push_back(8'h00);
        send_frame(0);
        make_arp(42, ARP_OP_REQUEST);
        send_frame(0);
        make_arp(LEN_ARP, ARP_OP_REPLY);
        send_frame(0);
        make_arp(60, 16'h0003);
        send_frame(0);
        make_ip6(LEN_IP6, PROTO_TCP, -1);
        send_frame(0);
        make_ip6(70, PROTO_UDP, -1);
        send_frame(0);
        make_ip6(80, PROTO_ICMP6, -1);
        send_frame(0);
        make_ip6(60, 8'd0, -1);
        send_frame(0);
        make_ip6(60, PROTO_TCP, 15);
        send_frame(0);
        make_tcp4(RST_BIT | SYN_BIT, HTTP_PORT, HTTP_PORT);
        send_frame(0);
        make_tcp4(SYN_BIT, 16'd1234, HTTP_PORT);
        send_frame(0);
        make_tcp4(ACK_BIT, 16'd1234, HTTP_PORT);
        send_frame(0);
        make_tcp4(ACK_BIT, HTTP_PORT, 16'd1234);
        send_frame(0);
        make_tcp4(ACK_BIT, 16'd443, 16'd5000);
        send_frame(0);
        make_ip4(LEN_IP4, 4'd5, PROTO_UDP, -1, '0, '0, '0);
        send_frame(0);
        make_ip4(60, 4'd5, PROTO_ICMP, -1, '0, '0, '0);
        send_frame(0);
        make_ip4(40, 4'd5, 8'hFF, -1, '0, '0, '0);
        send_frame(0);
        make_ip4(60, 4'd5, PROTO_TCP, 0, '0, '0, '0);
        send_frame(0);
        // frames cut short before the fields they need
        fill_random(1);
        send_frame(0);
        fill_random(LEN_ETH - 1);
        send_frame(0);
        make_arp(LEN_ARP - 1, ARP_OP_REQUEST);
        send_frame(0);
        make_ip6(LEN_IP6 - 1, PROTO_TCP, -1);
        send_frame(0);
        make_ip4(LEN_IP4 - 1, 4'd5, PROTO_UDP, -1, '0, '0, '0);
        send_frame(0);
        make_ip4(LEN_ETH + 60 + TCP_SPAN - 1, 4'd15, PROTO_TCP, -1, '0, '0, '0);
        send_frame(0);
        // IHL below 5 pulls the TCP fields into the IP header
        make_ip4(LEN_IP4, 4'd0, PROTO_TCP, -1, HTTP_PORT, '0, '0);
        send_frame(0);
        make_ip4(40, 4'd2, PROTO_TCP, -1, '0, HTTP_PORT, ACK_BIT);
        send_frame(0);
    endtask

    task automatic test_long_frame();
        make_ip4(FRAME_LIMIT + 6, 4'd5, PROTO_TCP, -1, HTTP_PORT, 16'd1234, ACK_BIT);
        send_frame(0);
    endtask

    task automatic test_alarms();
        wait_idle();
        set_reg(REG_SYN_THRESH, {32'($urandom), counts[CNT_SYN] + 32'd1});
        set_reg(REG_HTTP_THRESH, '0);
        repeat (3) begin
            make_tcp4(SYN_BIT, 16'($urandom), 16'($urandom));
            send_frame(0);
            make_tcp4(ACK_BIT, 16'($urandom), HTTP_PORT);
            send_frame(0);
        end
        wait_idle();
        set_reg(REG_SYN_THRESH, '1);
        set_reg(REG_HTTP_THRESH, '1);
        make_tcp4(SYN_BIT, HTTP_PORT, 16'd1234);
        send_frame(0);
        make_tcp4(ACK_BIT, HTTP_PORT, HTTP_PORT);
        send_frame(0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        // result side stalls long enough for last-byte items to back up
        hold_len = 80;
        repeat (3) begin
            fill_random(16);
            put16(POS_ETYPE_HI, ETH_LLDP);
            send_frame(1);
            make_arp(LEN_ARP, ARP_OP_REQUEST);
            send_frame(1);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        wait_idle();
        set_reg(REG_LOCAL_IPV4, rand64());
        set_reg(REG_LOCAL_IPV6H, rand64());
        set_reg(REG_LOCAL_IPV6L, rand64());
        set_reg(REG_SYN_THRESH, counts[CNT_SYN] + 32'($urandom_range(0, 6)));
        set_reg(REG_HTTP_THRESH, counts[CNT_HTTP] + 32'($urandom_range(0, 6)));
        run_traffic(450, 15);
        wait_idle();
        set_reg(REG_LOCAL_IPV4, '1);
        set_reg(REG_LOCAL_IPV6H, '1);
        set_reg(REG_LOCAL_IPV6L, '1);
        set_reg(REG_SYN_THRESH, '1);
        set_reg(REG_HTTP_THRESH, '1);
        run_traffic(450, 15);
        wait_idle();
        set_reg(REG_LOCAL_IPV4, '0);
        set_reg(REG_LOCAL_IPV6H, '0);
        set_reg(REG_LOCAL_IPV6L, '0);
        set_reg(REG_SYN_THRESH, '0);
        set_reg(REG_HTTP_THRESH, '0);
        run_traffic(450, 15);
        wait_idle();
        set_reg(REG_LOCAL_IPV4, rand64());
        set_reg(REG_LOCAL_IPV6H, rand64());
        set_reg(REG_LOCAL_IPV6L, rand64());
        set_reg(REG_SYN_THRESH, counts[CNT_SYN] + 32'($urandom_range(0, 4)));
        set_reg(REG_HTTP_THRESH, counts[CNT_HTTP] + 32'($urandom_range(0, 4)));
        calm = 1'b1;
        run_traffic(450, 15);
    endtask

    initial begin
        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame_byte  <= '0;
        frame_end   <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_register_writes();
        test_frame_classes();
        test_long_frame();
        test_alarms();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_packet_header_classifier_counters: clean");
        else
            $display("tb_packet_header_classifier_counters: errors");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb_packet_header_classifier_counters: errors");
        $finish;
    end

endmodule
